// ===== rtl/core/wfag_pkg.sv =====
// Shared constants, field widths and helpers for the window frame-buffer
// address generator. No dependencies.
package wfag_pkg;

  localparam int unsigned FRAME_WIDTH_DEF  = 480;
  localparam int unsigned FRAME_HEIGHT_DEF = 320;
  localparam int unsigned BYTES_PER_PIXEL  = 3;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned ADDR_W    = 19;
  localparam int unsigned CFG_IN_W  = 9;
  localparam int unsigned CFG_IDX_W = 2;
  // stored registers hold the frame size itself, up to 2047
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned ROW_W     = 11;
  localparam int unsigned MUL_W     = 24;
  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_COLUMN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_COLUMN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_ROW      = 2'd3;

  function automatic logic [CFG_W-1:0] sat_to(input logic [CFG_IN_W-1:0] v,
                                              input logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] x;
    x = {{(CFG_W-CFG_IN_W){1'b0}}, v};
    return (x > lim) ? lim : x;
  endfunction

  function automatic logic [COL_W-1:0] times3(input logic [CFG_W-1:0] v);
    logic [COL_W-1:0] x;
    x = {{(COL_W-CFG_W){1'b0}}, v};
    return (x << 1) + x;
  endfunction

endpackage

// ===== rtl/core/window_framebuffer_address_gen.sv =====
// Window frame-buffer address generator: top level.
// Depends on wfag_pkg for widths, register indexes and helpers.
//
// Each accepted color byte yields exactly one output word in the next cycle:
// the frame-buffer byte address, the byte itself and a write enable. A new
// byte is taken every cycle unless the output stalls; the only storage in
// the path is the cursor state and the output register, so throughput is
// one word per clock. The output register holds a word while m_tready is
// low, and the input side keeps accepting as soon as that word drains.
// Window registers are written through cfg_we/cfg_index/cfg_data and are
// saturated to the frame size.
module window_framebuffer_address_gen #(
  parameter int unsigned FRAME_WIDTH  = wfag_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = wfag_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [wfag_pkg::TDATA_IN_W-1:0]    s_tdata,   // [7:0] color_byte
  input  logic                               s_tuser,   // [0] burst_start
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [wfag_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [18:0] byte_address, [26:19] write_data
  output logic                               m_tuser,   // [0] write_enable
  input  logic                               cfg_we,
  input  logic [wfag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wfag_pkg::CFG_IN_W-1:0]      cfg_data
);
  import wfag_pkg::*;

  localparam logic [CFG_W-1:0] WIDTH_LIM  = CFG_W'(FRAME_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_LIM = CFG_W'(FRAME_HEIGHT);
  localparam logic [COL_W:0]   ROW_BYTES  = (COL_W+1)'(BYTES_PER_PIXEL * FRAME_WIDTH);
  localparam logic [ROW_W-1:0] ROW_LIM    = ROW_W'(FRAME_HEIGHT);

  logic [CFG_W-1:0] start_column, end_column, start_row, end_row;
  logic [COL_W-1:0] column_cursor, column_cursor_next;
  logic [ROW_W-1:0] row_cursor, row_cursor_next;
  logic             burst_finished, burst_finished_next;

  logic             accept;
  logic [COL_W-1:0] col_e, col_start;
  logic [ROW_W-1:0] row_e;
  logic             fin_e;
  logic [COL_W:0]   col_inc;
  logic             wrap;
  logic [ROW_W-1:0] row_inc;
  logic             in_frame;
  logic [MUL_W-1:0] row_off;
  logic [ADDR_W-1:0] addr;
  logic             wen;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_column <= '0;
      end_column   <= WIDTH_LIM;
      start_row    <= '0;
      end_row      <= HEIGHT_LIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_COLUMN: start_column <= sat_to(cfg_data, WIDTH_LIM);
        REG_END_COLUMN:   end_column   <= sat_to(cfg_data, WIDTH_LIM);
        REG_START_ROW:    start_row    <= sat_to(cfg_data, HEIGHT_LIM);
        REG_END_ROW:      end_row      <= sat_to(cfg_data, HEIGHT_LIM);
        default: ;
      endcase
    end
  end

  always_comb begin
    col_start = times3(start_column);
    col_e     = s_tuser ? col_start : column_cursor;
    row_e     = s_tuser ? ROW_W'(start_row) : row_cursor;
    fin_e     = s_tuser ? 1'b0 : burst_finished;

    in_frame  = ({1'b0, col_e} < ROW_BYTES) && (row_e < ROW_LIM);
    row_off   = MUL_W'(row_e) * MUL_W'(ROW_BYTES);
    addr      = ADDR_W'(row_off + MUL_W'(col_e));
    wen       = !fin_e && in_frame;

    col_inc   = {1'b0, col_e} + (COL_W+1)'(1);
    wrap      = col_inc >= {1'b0, times3(end_column)};
    row_inc   = row_e + ROW_W'(wrap);

    if (fin_e) begin
      column_cursor_next  = col_e;
      row_cursor_next     = row_e;
      burst_finished_next = 1'b1;
    end else begin
      column_cursor_next  = wrap ? col_start : col_inc[COL_W-1:0];
      row_cursor_next     = row_inc;
      burst_finished_next = row_inc >= ROW_W'(end_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_cursor  <= '0;
      row_cursor     <= '0;
      burst_finished <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        column_cursor  <= column_cursor_next;
        row_cursor     <= row_cursor_next;
        burst_finished <= burst_finished_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{(TDATA_OUT_W-ADDR_W-DATA_W){1'b0}}, s_tdata[DATA_W-1:0],
                  wen ? addr : {ADDR_W{1'b0}}};
      m_tuser <= wen;
    end
  end

  a_drop_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[ADDR_W-1:0] == '0)
    else $error("dropped word carries nonzero address");

  a_finished_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tuser && burst_finished |=>
      $stable(column_cursor) && $stable(row_cursor) && burst_finished)
    else $error("cursor moved after burst finished");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted byte produced no output word");

endmodule

// ===== dv/window_framebuffer_address_gen_tb.sv =====
`timescale 1ns / 1ps
// Testbench for window_framebuffer_address_gen: streams color bytes under directed and random window
// settings and checks every output word against an internal cursor predictor.
// Depends on wfag_pkg and the window_framebuffer_address_gen RTL.
module window_framebuffer_address_gen_tb;
  import wfag_pkg::*;

  localparam int unsigned ROW_BYTES   = FRAME_WIDTH_DEF * BYTES_PER_PIXEL;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              we;
  } fb_write_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;   // [7:0] color_byte
  logic                   s_tuser = 1'b0; // [0] burst_start
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;        // [18:0] byte_address, [26:19] write_data
  logic                   m_tuser;        // [0] write_enable
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_IN_W-1:0]    cfg_data = '0;

  fb_write_t   pending_writes[$];
  int unsigned win_sc, win_ec, win_sr, win_er;
  int unsigned col_pos, row_pos;
  bit          burst_done;
  int          bytes_sent = 0;
  int          words_seen = 0;
  int          errors = 0;
  int          idle_pct = 0;
  int          cycle_count = 0;

  window_framebuffer_address_gen u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void reset_cursor_model();
    win_sc     = 0;
    win_ec     = FRAME_WIDTH_DEF;
    win_sr     = 0;
    win_er     = FRAME_HEIGHT_DEF;
    col_pos    = 0;
    row_pos    = 0;
    burst_done = 1'b0;
  endfunction

  function automatic void load_window_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_IN_W-1:0] v);
    int unsigned val;
    val = v;
    case (idx)
      REG_START_COLUMN: win_sc = (val > FRAME_WIDTH_DEF) ? FRAME_WIDTH_DEF : val;
      REG_END_COLUMN:   win_ec = (val > FRAME_WIDTH_DEF) ? FRAME_WIDTH_DEF : val;
      REG_START_ROW:    win_sr = (val > FRAME_HEIGHT_DEF) ? FRAME_HEIGHT_DEF : val;
      REG_END_ROW:      win_er = (val > FRAME_HEIGHT_DEF) ? FRAME_HEIGHT_DEF : val;
      default: ;
    endcase
  endfunction

  function automatic fb_write_t place_byte(input logic [DATA_W-1:0] b, input logic first);
    fb_write_t   w;
    int unsigned addr;
    if (first) begin
      col_pos    = win_sc * BYTES_PER_PIXEL;
      row_pos    = win_sr;
      burst_done = 1'b0;
    end
    w.data = b;
    w.addr = '0;
    w.we   = 1'b0;
    if (burst_done) return w;
    if (col_pos < ROW_BYTES && row_pos < FRAME_HEIGHT_DEF) begin
      addr   = col_pos + row_pos * ROW_BYTES;
      w.addr = addr[ADDR_W-1:0];
      w.we   = 1'b1;
    end
    col_pos++;
    if (col_pos >= win_ec * BYTES_PER_PIXEL) begin
      col_pos = win_sc * BYTES_PER_PIXEL;
      row_pos++;
    end
    if (row_pos >= win_er) burst_done = 1'b1;
    return w;
  endfunction

  always @(posedge clk) begin
    fb_write_t got, want;
    if (rst) begin
      reset_cursor_model();
    end else begin
      if (cfg_we) load_window_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) pending_writes.push_back(place_byte(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        words_seen++;
        got.addr = m_tdata[ADDR_W-1:0];
        got.data = m_tdata[ADDR_W+DATA_W-1:ADDR_W];
        got.we   = m_tuser;
        if (pending_writes.size() == 0) begin
          $error("unexpected word: byte_address %0d", got.addr);
          errors++;
        end else begin
          want = pending_writes.pop_front();
          if (got.addr !== want.addr) begin
            $error("byte_address: expected %0d, got %0d", want.addr, got.addr);
            errors++;
          end
          if (got.data !== want.data) begin
            $error("write_data: expected %0d, got %0d", want.data, got.data);
            errors++;
          end
          if (got.we !== want.we) begin
            $error("write_enable: expected %0d, got %0d", want.we, got.we);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stall the output side in bursts
  always begin
    @(posedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    m_tready <= 1'b1;
  end

  task automatic send_byte(input logic [DATA_W-1:0] b, input logic first);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (words_seen != bytes_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_IN_W-1:0] v,
                         input bit last_one);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    if (last_one) cfg_we <= 1'b0;
  endtask

  task automatic set_window(input logic [CFG_IN_W-1:0] sc, input logic [CFG_IN_W-1:0] ec,
                            input logic [CFG_IN_W-1:0] sr, input logic [CFG_IN_W-1:0] er);
    wait_idle();
    put_reg(REG_START_COLUMN, sc, 1'b0);
    put_reg(REG_END_COLUMN, ec, 1'b0);
    put_reg(REG_START_ROW, sr, 1'b0);
    put_reg(REG_END_ROW, er, 1'b1);
  endtask

  task automatic test_after_reset();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_register_saturation();
    set_window(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
  endtask

  task automatic test_frame_corners();
    set_window(9'd479, 9'd480, 9'd319, 9'd320);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    set_window(9'd0, 9'd1, 9'd0, 9'd1);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hEE, 1'b0);
  endtask

  task automatic test_inverted_window();
    set_window(9'd2, 9'd0, 9'd0, 9'd4);
    send_byte(8'h10, 1'b1);
    send_byte(8'h20, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h04, 1'b0);
  endtask

  task automatic pick_window(output int unsigned span);
    logic [CFG_IN_W-1:0] sc, ec, sr, er;
    case ($urandom_range(0, 5))
      0: begin
        sc = 9'($urandom);
        ec = 9'($urandom);
        sr = 9'($urandom);
        er = 9'($urandom);
      end
      1: begin
        sc = 9'($urandom_range(476, 480));
        ec = sc + 9'($urandom_range(0, 3));
        sr = 9'($urandom_range(316, 320));
        er = sr + 9'($urandom_range(0, 3));
      end
      default: begin
        sc = 9'($urandom_range(0, 476));
        ec = sc + 9'($urandom_range(1, 4));
        sr = 9'($urandom_range(0, 316));
        er = sr + 9'($urandom_range(1, 4));
      end
    endcase
    set_window(sc, ec, sr, er);
    span = ((ec > sc) ? ec - sc : 1) * BYTES_PER_PIXEL * ((er > sr) ? er - sr : 1);
    if (span > 60) span = 60;
  endtask

  task automatic test_random_bursts(input int unsigned n_items, input int pct);
    int unsigned done_items, span, len, mode, n_bursts;
    logic        first;
    done_items = 0;
    while (done_items < n_items) begin
      pick_window(span);
      idle_pct = ($urandom_range(0, 2) == 0) ? 0 : pct;
      n_bursts = $urandom_range(2, 6);
      for (int b = 0; b < n_bursts; b++) begin
        mode = $urandom_range(0, 9);
        if (mode == 0) len = $urandom_range(1, 8);
        else if (mode == 1) len = $urandom_range(1, span);
        else len = span + $urandom_range(0, 4);
        for (int k = 0; k < len; k++) begin
          if (mode == 0) first = 1'b0;
          else if (mode == 2) first = (k == 0) || ($urandom_range(0, 15) == 0);
          else first = (k == 0);
          send_byte(8'($urandom), first);
        end
        done_items += len;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;
    test_after_reset();
    test_register_saturation();
    test_frame_corners();
    test_inverted_window();
    test_random_bursts(1500, 25);
    test_random_bursts(200, 0);
    idle_pct = 0;
    wait_idle();
    repeat (5) @(posedge clk);
    if (pending_writes.size() != 0) begin
      $error("%0d expected words never arrived", pending_writes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== window_framebuffer_address_gen.f =====
rtl/core/wfag_pkg.sv
rtl/core/window_framebuffer_address_gen.sv
dv/window_framebuffer_address_gen_tb.sv
